@@ rtl/cdq_pkg.sv @@
package cdq_pkg;

    localparam int DEPTH_DEF = 128;
    localparam int WORD_W    = 32;
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INS_FRONT = 2'd0,
        FUNC_INS_REAR  = 2'd1,
        FUNC_DEL_FRONT = 2'd2,
        FUNC_DEL_REAR  = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the incoming word
        logic exec;     // perform the operation on pointers and ring
        logic load;     // move the result into the output registers
    } dp_cmd_t;

endpackage

@@ rtl/cdq_ctrl.sv @@
module cdq_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    output cdq_pkg::dp_cmd_t cmd
);
    import cdq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LOAD = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // output register can take a new word when empty or being drained
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/cdq_dp.sv @@
module cdq_dp
#(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  cdq_pkg::dp_cmd_t                  cmd,
    input  logic [cdq_pkg::FUNC_W-1:0]        func,
    input  logic signed [cdq_pkg::WORD_W-1:0] data,
    output logic signed [cdq_pkg::WORD_W-1:0] value,
    output logic [cdq_pkg::STATUS_W-1:0]      status,
    output logic                              is_empty,
    output logic                              is_full
);
    import cdq_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W-1:0] ZERO = '0;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST) ? ZERO : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == ZERO) ? LAST : p - PTR_W'(1);
    endfunction

    logic [WORD_W-1:0] ring_mem [DEPTH];

    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic              empty_reg, empty_next;

    func_t             op_reg;
    logic [WORD_W-1:0] word_reg;
    status_t           st_reg, st_next;
    logic              take_reg, take_next;
    logic [WORD_W-1:0] rd_reg;

    logic              we, re;
    logic [PTR_W-1:0]  waddr, raddr;
    logic              full;

    logic [WORD_W-1:0]   value_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                is_empty_reg;
    logic                is_full_reg;

    assign full = !empty_reg && (ptr_inc(tail_reg) == head_reg);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        empty_next = empty_reg;
        st_next    = st_reg;
        take_next  = take_reg;
        we         = 1'b0;
        re         = 1'b0;
        waddr      = ZERO;
        raddr      = ZERO;

        if (cmd.exec)
        begin
            st_next   = ST_DONE;
            take_next = 1'b0;
            unique case (op_reg)
                FUNC_INS_FRONT, FUNC_INS_REAR:
                begin
                    if (full)
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        we = 1'b1;
                        priority if (empty_reg)
                        begin
                            // first word restarts both ends at slot zero
                            head_next  = ZERO;
                            tail_next  = ZERO;
                            empty_next = 1'b0;
                            waddr      = ZERO;
                        end
                        else if (op_reg == FUNC_INS_FRONT)
                        begin
                            head_next = ptr_dec(head_reg);
                            waddr     = ptr_dec(head_reg);
                        end
                        else
                        begin
                            tail_next = ptr_inc(tail_reg);
                            waddr     = ptr_inc(tail_reg);
                        end
                    end
                end
                FUNC_DEL_FRONT, FUNC_DEL_REAR:
                begin
                    if (empty_reg)
                    begin
                        st_next = ST_EMPTY;
                    end
                    else
                    begin
                        re        = 1'b1;
                        take_next = 1'b1;
                        raddr     = (op_reg == FUNC_DEL_FRONT) ? head_reg : tail_reg;
                        priority if (head_reg == tail_reg)
                        begin
                            empty_next = 1'b1;
                        end
                        else if (op_reg == FUNC_DEL_FRONT)
                        begin
                            head_next = ptr_inc(head_reg);
                        end
                        else
                        begin
                            tail_next = ptr_dec(tail_reg);
                        end
                    end
                end
                default:
                begin
                    st_next = ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= ZERO;
            tail_reg  <= ZERO;
            empty_reg <= 1'b1;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ring_mem[waddr] <= word_reg;
        end
        if (re)
        begin
            rd_reg <= ring_mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= func_t'(func);
            word_reg <= data;
        end
        st_reg   <= st_next;
        take_reg <= take_next;
        if (cmd.load)
        begin
            value_reg    <= take_reg ? rd_reg : '0;
            status_reg   <= st_reg;
            is_empty_reg <= empty_reg;
            is_full_reg  <= full;
        end
    end

    assign value    = value_reg;
    assign status   = status_reg;
    assign is_empty = is_empty_reg;
    assign is_full  = is_full_reg;

endmodule

@@ rtl/circular_deque.sv @@
// Double-ended queue of DEPTH 32-bit words held in a ring. Each input word
// carries func (insert front, insert rear, delete front, delete rear) and data;
// each yields exactly one result with the removed word (zero otherwise), a
// status (done, refused full, refused empty) and the empty and full flags after
// the operation. An operation passes three steps: capture at the accepting
// edge, one ring access with pointer update, then result load, which waits
// while the output register holds a stalled result; the ring's registered
// read port is why the load is a step of its own. One operation is in flight
// at a time, so a new word is taken only once the last one's result is loaded.
// The ring needs no clearing after reset.
module circular_deque
#(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [cdq_pkg::FUNC_W-1:0]        func,
    input  logic signed [cdq_pkg::WORD_W-1:0] data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [cdq_pkg::WORD_W-1:0] value,
    output logic [cdq_pkg::STATUS_W-1:0]      status,
    output logic                              is_empty,
    output logic                              is_full
);
    import cdq_pkg::*;

    dp_cmd_t cmd;

    cdq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    cdq_dp #(.DEPTH(DEPTH)) u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .func     (func),
        .data     (data),
        .value    (value),
        .status   (status),
        .is_empty (is_empty),
        .is_full  (is_full)
    );

endmodule

@@ test/circular_deque_test.sv @@
`timescale 1ns / 1ps

module circular_deque_test;

    import cdq_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 200;
    localparam int IDLE_PCT    = 11;

    typedef struct {
        logic signed [WORD_W-1:0] value;
        status_t                  status;
        logic                     is_empty;
        logic                     is_full;
    } deque_result_t;

    // Shadow copy of the deque: predicts one result per accepted word
    class deque_shadow;
        logic signed [WORD_W-1:0] ring [DEPTH];
        int unsigned              head;
        int unsigned              tail;
        bit                       empty;
        deque_result_t            owed [$];
        int                       errors;
        int                       ops;
        int                       returned;
        int                       refused_full;
        int                       refused_empty;

        function new();
            head          = 0;
            tail          = 0;
            empty         = 1'b1;
            errors        = 0;
            ops           = 0;
            returned      = 0;
            refused_full  = 0;
            refused_empty = 0;
        endfunction

        function int unsigned step_up(int unsigned p);
            return (p + 1 == DEPTH) ? 0 : p + 1;
        endfunction

        function int unsigned step_down(int unsigned p);
            return (p == 0) ? DEPTH - 1 : p - 1;
        endfunction

        function bit full();
            return !empty && step_up(tail) == head;
        endfunction

        function void note_op(func_t f, logic signed [WORD_W-1:0] d);
            deque_result_t r;
            int unsigned   slot;
            r.value  = '0;
            r.status = ST_DONE;
            ops++;
            if (f == FUNC_INS_FRONT || f == FUNC_INS_REAR)
            begin
                if (full())
                begin
                    r.status = ST_FULL;
                    refused_full++;
                end
                else
                begin
                    if (empty)
                    begin
                        // first word into an empty deque lands in slot zero
                        head  = 0;
                        tail  = 0;
                        empty = 1'b0;
                        slot  = 0;
                    end
                    else if (f == FUNC_INS_FRONT)
                    begin
                        head = step_down(head);
                        slot = head;
                    end
                    else
                    begin
                        tail = step_up(tail);
                        slot = tail;
                    end
                    ring[slot] = d;
                end
            end
            else
            begin
                if (empty)
                begin
                    r.status = ST_EMPTY;
                    refused_empty++;
                end
                else
                begin
                    slot    = (f == FUNC_DEL_FRONT) ? head : tail;
                    r.value = ring[slot];
                    returned++;
                    // last entry: pointers left stale until the next insert
                    if (head == tail)
                        empty = 1'b1;
                    else if (f == FUNC_DEL_FRONT)
                        head = step_up(head);
                    else
                        tail = step_down(tail);
                end
            end
            r.is_empty = empty;
            r.is_full  = full();
            owed.push_back(r);
        endfunction

        function void check_result(logic signed [WORD_W-1:0] v, logic [STATUS_W-1:0] s,
                                   logic e, logic f);
            deque_result_t x;
            if (owed.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result with nothing owed: value %h status %0d", v, s);
                return;
            end
            x = owed.pop_front();
            if (v !== x.value || s !== x.status || e !== x.is_empty || f !== x.is_full)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("ERROR: value exp %h got %h, status exp %0d got %0d",
                             x.value, v, x.status, s);
                    $display("       empty exp %0d got %0d, full exp %0d got %0d",
                             x.is_empty, e, x.is_full, f);
                end
            end
        endfunction
    endclass

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic [FUNC_W-1:0]        func      = '0;
    logic signed [WORD_W-1:0] data      = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [WORD_W-1:0] value;
    logic [STATUS_W-1:0]      status;
    logic                     is_empty;
    logic                     is_full;

    deque_shadow shadow = new();
    bit          quiet;
    int          hold_left;
    int          cycle_count;

    circular_deque i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .data      (data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .status    (status),
        .is_empty  (is_empty),
        .is_full   (is_full)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver: random stalls, or a long hold-off when asked
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (!quiet && $urandom_range(99) < IDLE_PCT)
                out_stall <= 1'b1;
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                shadow.check_result(value, status, is_empty, is_full);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("ERROR: run timed out after %0d cycles", cycle_count);
        $display("Test completed with failures");
        $finish;
    end

    task automatic put_word(func_t f, logic signed [WORD_W-1:0] d);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        data     <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        shadow.note_op(f, d);
    endtask

    // random words with a given share of inserts
    task automatic churn(int count, int ins_pct);
        func_t f;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < ins_pct)
                f = func_t'($urandom_range(1));
            else
                f = func_t'(2 + $urandom_range(1));
            put_word(f, $urandom());
        end
    endtask

    initial
    begin
        quiet     = 1'b0;
        hold_left = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // deletes straight after reset are refused
        put_word(FUNC_DEL_FRONT, $urandom());
        put_word(FUNC_DEL_REAR, $urandom());
        put_word(FUNC_INS_FRONT, 32'h7fffffff);
        put_word(FUNC_INS_FRONT, 32'h80000000);   // head wraps below slot zero
        put_word(FUNC_INS_REAR, 32'hffffffff);
        put_word(FUNC_INS_REAR, 32'h00000000);
        put_word(FUNC_DEL_FRONT, $urandom());
        put_word(FUNC_DEL_REAR, $urandom());
        put_word(FUNC_DEL_REAR, $urandom());
        put_word(FUNC_DEL_FRONT, $urandom());      // last entry out
        put_word(FUNC_DEL_REAR, $urandom());
        put_word(FUNC_INS_REAR, 32'h55555555);     // pointers were stale
        put_word(FUNC_DEL_REAR, $urandom());
        put_word(FUNC_INS_FRONT, 32'haaaaaaaa);
        put_word(FUNC_INS_REAR, 32'h00000001);
        put_word(FUNC_DEL_FRONT, $urandom());
        put_word(FUNC_DEL_FRONT, $urandom());
        put_word(FUNC_DEL_FRONT, $urandom());

        churn(250, 85);
        quiet = 1'b1;
        churn(150, 50);
        quiet = 1'b0;
        churn(250, 15);
        hold_left = HOLD_CYCLES;
        churn(250, 85);
        churn(150, 15);

        @(negedge clk);
        in_valid <= 1'b0;
        while (shadow.owed.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Ran %0d words: %0d returned, %0d refused full, %0d refused empty.",
                 shadow.ops, shadow.returned, shadow.refused_full, shadow.refused_empty);
        $display("Mismatches: %0d, results still owed: %0d, cycles: %0d",
                 shadow.errors, shadow.owed.size(), cycle_count);
        if (shadow.errors == 0 && shadow.owed.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ circular_deque.f @@
rtl/cdq_pkg.sv
rtl/cdq_ctrl.sv
rtl/cdq_dp.sv
rtl/circular_deque.sv
test/circular_deque_test.sv
